// ----- hw/rtl/pressure_temp_compensation_core_macros.svh -----
// Assertion macros shared by the compensation datapath modules.
// No dependencies.
`ifndef PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH
`define PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH
// implication checked at every clock, off during reset
`define PTC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptc assertion failed");
// next-cycle implication
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptc assertion failed");
`endif

// ----- hw/rtl/ptc_pkg.sv -----
// Package for the pressure/temperature compensation core.
// Types, constants and arithmetic helpers; no dependencies.
package ptc_pkg;

  localparam int unsigned RawW   = 20;
  localparam int unsigned DataW  = 32;
  localparam int unsigned TrimW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 64;
  localparam int unsigned DivSteps = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTempTrim  = 2'd0,
    CfgPressA    = 2'd1,
    CfgPressB    = 2'd2,
    CfgPressC    = 2'd3
  } cfg_idx_e;

  typedef logic [DataW-1:0] word_t;

  typedef struct packed {
    logic [TrimW-1:0] t1, t2, t3;
    logic [TrimW-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } trim_t;

  localparam word_t PressOffset = 32'd64000;
  localparam word_t HalfScale   = 32'd32768;
  localparam word_t RawSpan     = 32'd1048576;
  localparam word_t PaScale     = 32'd3125;
  localparam word_t RoundBias   = 32'd128;
  localparam word_t TopBit      = 32'h8000_0000;

  function automatic word_t sx16(input logic [TrimW-1:0] v);
    return {{(DataW-TrimW){v[TrimW-1]}}, v};
  endfunction

  function automatic word_t ux16(input logic [TrimW-1:0] v);
    return {{(DataW-TrimW){1'b0}}, v};
  endfunction

  function automatic word_t mul32(input word_t a, input word_t b);
    logic [2*DataW-1:0] p;
    p = a * b;
    return p[DataW-1:0];
  endfunction

  function automatic word_t asr(input word_t x, input int unsigned s);
    return word_t'($signed(x) >>> s);
  endfunction

endpackage

// ----- hw/rtl/pressure_temp_compensation_core.sv -----
// Pressure/temperature compensation core: 32-bit integer sensor compensation.
// Uses ptc_pkg, ptc_front, ptc_div, ptc_back and the macro header.
//
// Usage:
//  - Input channel in_valid_i/in_ready_o carries raw_temp_i and raw_press_i.
//  - Output channel out_valid_o/out_ready_i carries temp_centi_o, press_pa_o
//    and press_invalid_o, one word per input word, in order.
//  - Config channel cfg_valid_i/cfg_ready_o writes trim register cfg_index_i
//    (0 temp, 1..3 pressure) with cfg_data_i; write only when idle.
// Throughput: one word per cycle while the output word is taken, fully pipelined.
// Pipeline: 6 front stages, 33 divider stages (all but the first yield one
//  quotient bit each) and 3 back stages.
// Reset clears all valid bits and trims to zero.
// Stall: the whole pipeline freezes while the output word is not taken;
//  in_ready_o follows out_ready_i or an empty output slot.
`include "pressure_temp_compensation_core_macros.svh"
module pressure_temp_compensation_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ptc_pkg::RawW-1:0]       raw_temp_i,
  input  logic [ptc_pkg::RawW-1:0]       raw_press_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [ptc_pkg::DataW-1:0] temp_centi_o,
  output logic [ptc_pkg::DataW-1:0]      press_pa_o,
  output logic                           press_invalid_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ptc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ptc_pkg::CfgDatW-1:0]    cfg_data_i
);
  import ptc_pkg::*;

  logic [47:0] temp_trim_q;
  logic [63:0] press_a_q, press_b_q;
  logic [15:0] press_c_q;
  trim_t trim;
  logic en;
  logic fv, dv;
  word_t ft, fn, fd, dt, dq;
  logic dinv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q <= '0; press_a_q <= '0; press_b_q <= '0; press_c_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgTempTrim: temp_trim_q <= cfg_data_i[47:0];
        CfgPressA:   press_a_q   <= cfg_data_i;
        CfgPressB:   press_b_q   <= cfg_data_i;
        CfgPressC:   press_c_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    trim.t1 = temp_trim_q[15:0];
    trim.t2 = temp_trim_q[31:16];
    trim.t3 = temp_trim_q[47:32];
    trim.p1 = press_a_q[15:0];
    trim.p2 = press_a_q[31:16];
    trim.p3 = press_a_q[47:32];
    trim.p4 = press_a_q[63:48];
    trim.p5 = press_b_q[15:0];
    trim.p6 = press_b_q[31:16];
    trim.p7 = press_b_q[47:32];
    trim.p8 = press_b_q[63:48];
    trim.p9 = press_c_q;
  end

  assign en = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  ptc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .trim_i(trim),
    .raw_temp_i, .raw_press_i,
    .valid_o(fv), .temp_o(ft), .num_o(fn), .den_o(fd)
  );

  ptc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv), .temp_i(ft), .num_i(fn), .den_i(fd),
    .valid_o(dv), .temp_o(dt), .quot_o(dq), .invalid_o(dinv)
  );

  word_t tc, pp;
  ptc_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv), .trim_i(trim),
    .temp_i(dt), .p_i(dq), .invalid_i(dinv),
    .valid_o(out_valid_o), .temp_o(tc), .press_o(pp), .invalid_o(press_invalid_o)
  );

  assign temp_centi_o = $signed(tc);
  assign press_pa_o   = pp;

  `PTC_ASSERT(a_top_ready, out_valid_o && !out_ready_i, !in_ready_o)
  `PTC_ASSERT_NEXT(a_top_stall, out_valid_o && !out_ready_i, out_valid_o)
  `PTC_ASSERT(a_top_cfg, 1'b1, cfg_ready_o)

endmodule

// ----- hw/rtl/ptc_front.sv -----
// Front stages: temperature and the pressure denominator/numerator.
// Depends on ptc_pkg and the macro header.
`include "pressure_temp_compensation_core_macros.svh"
module ptc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  ptc_pkg::trim_t          trim_i,
  input  logic [ptc_pkg::RawW-1:0] raw_temp_i,
  input  logic [ptc_pkg::RawW-1:0] raw_press_i,
  output logic                    valid_o,
  output ptc_pkg::word_t          temp_o,
  output ptc_pkg::word_t          num_o,
  output ptc_pkg::word_t          den_o
);
  import ptc_pkg::*;

  // stage 1: first products
  logic  v1_q, v1_d;
  word_t ta_q, ta_d, dd_q, dd_d;
  logic [RawW-1:0] rp1_q;
  // stage 2
  logic  v2_q;
  word_t fine_q, fine_d;
  logic [RawW-1:0] rp2_q;
  // stage 3
  logic  v3_q;
  word_t temp3_q, temp3_d, pa_q, pa_d, qq_q, qq_d;
  logic [RawW-1:0] rp3_q;
  // stage 4
  logic  v4_q;
  word_t temp4_q, b6_q, b6_d, b5_q, b5_d, c3_q, c3_d, c2_q, c2_d;
  logic [RawW-1:0] rp4_q;
  // stage 5
  logic  v5_q;
  word_t temp5_q, bsum_q, bsum_d, asum_q, asum_d;
  logic [RawW-1:0] rp5_q;
  // stage 6
  word_t bnum_d, aden_d;

  word_t t1, t2, t3, p1, p2, p3, p4, p5, p6;
  word_t adc_t, d_tmp, a_tmp;

  always_comb begin
    t1 = ux16(trim_i.t1);
    t2 = sx16(trim_i.t2);
    t3 = sx16(trim_i.t3);
    p1 = ux16(trim_i.p1);
    p2 = sx16(trim_i.p2);
    p3 = sx16(trim_i.p3);
    p4 = sx16(trim_i.p4);
    p5 = sx16(trim_i.p5);
    p6 = sx16(trim_i.p6);
    adc_t = {{(DataW-RawW){1'b0}}, raw_temp_i};
    v1_d = valid_i;
    ta_d = asr(mul32((adc_t >> 3) - (t1 << 1), t2), 11);
    d_tmp = (adc_t >> 4) - t1;
    dd_d = asr(mul32(d_tmp, d_tmp), 12);
    fine_d = ta_q + asr(mul32(dd_q, t3), 14);
    temp3_d = asr(mul32(fine_q, 32'd5) + RoundBias, 8);
    pa_d = asr(fine_q, 1) - PressOffset;
    qq_d = mul32(asr(asr(fine_q, 1) - PressOffset, 2),
                 asr(asr(fine_q, 1) - PressOffset, 2));
    b6_d = mul32(asr(qq_q, 11), p6);
    b5_d = mul32(pa_q, p5) << 1;
    c3_d = mul32(p3, asr(qq_q, 13));
    c2_d = mul32(p2, pa_q);
    bsum_d = asr(b6_q + b5_q, 2) + (p4 << 16);
    asum_d = asr(asr(c3_q, 3) + asr(c2_q, 1), 18);
    a_tmp = HalfScale + asum_q;
    aden_d = asr(mul32(a_tmp, p1), 15);
    bnum_d = mul32((RawSpan - {{(DataW-RawW){1'b0}}, rp5_q}) - asr(bsum_q, 12),
                   PaScale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q <= v1_d; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
      valid_o <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q <= ta_d; dd_q <= dd_d; rp1_q <= raw_press_i;
      fine_q <= fine_d; rp2_q <= rp1_q;
      temp3_q <= temp3_d; pa_q <= pa_d; qq_q <= qq_d; rp3_q <= rp2_q;
      temp4_q <= temp3_q; b6_q <= b6_d; b5_q <= b5_d; c3_q <= c3_d; c2_q <= c2_d;
      rp4_q <= rp3_q;
      temp5_q <= temp4_q; bsum_q <= bsum_d; asum_q <= asum_d; rp5_q <= rp4_q;
      temp_o <= temp5_q; num_o <= bnum_d; den_o <= aden_d;
    end
  end

  `PTC_ASSERT_NEXT(a_front_hold, !en_i, $stable(valid_o))
  `PTC_ASSERT_NEXT(a_front_adv, en_i && v5_q, valid_o)
  `PTC_ASSERT_NEXT(a_front_drop, en_i && !v5_q, !valid_o)

endmodule

// ----- hw/rtl/ptc_div.sv -----
// Pipelined restoring divider, an input stage then one quotient bit per stage, plus doubling rule.
// Depends on ptc_pkg and the macro header.
`include "pressure_temp_compensation_core_macros.svh"
module ptc_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  ptc_pkg::word_t temp_i,
  input  ptc_pkg::word_t num_i,
  input  ptc_pkg::word_t den_i,
  output logic           valid_o,
  output ptc_pkg::word_t temp_o,
  output ptc_pkg::word_t quot_o,
  output logic           invalid_o
);
  import ptc_pkg::*;

  typedef struct packed {
    logic         inv;
    logic         dbl;
    logic [DataW-1:0] temp;
    logic [DataW-1:0] den;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
  } dstage_t;

  dstage_t st_q [DivSteps+1];
  dstage_t st_d [DivSteps+1];
  logic    vld_q [DivSteps+1];
  logic [DataW:0] trial [DivSteps];

  always_comb begin
    st_d[0].inv  = (den_i == '0);
    st_d[0].dbl  = (num_i >= TopBit);
    st_d[0].temp = temp_i;
    st_d[0].den  = den_i;
    st_d[0].rem  = '0;
    st_d[0].quo  = (num_i >= TopBit) ? num_i : (num_i << 1);
    for (int i = 0; i < DivSteps; i++) begin
      trial[i] = {st_q[i].rem, st_q[i].quo[DataW-1]};
      st_d[i+1] = st_q[i];
      if (trial[i] >= {1'b0, st_q[i].den}) begin
        st_d[i+1].rem = 32'(trial[i] - {1'b0, st_q[i].den});
        st_d[i+1].quo = {st_q[i].quo[DataW-2:0], 1'b1};
      end else begin
        st_d[i+1].rem = trial[i][DataW-1:0];
        st_d[i+1].quo = {st_q[i].quo[DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DivSteps; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i <= DivSteps; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i <= DivSteps; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign valid_o   = vld_q[DivSteps];
  assign temp_o    = st_q[DivSteps].temp;
  assign invalid_o = st_q[DivSteps].inv;
  assign quot_o    = st_q[DivSteps].inv ? '0 :
                     (st_q[DivSteps].dbl ? (st_q[DivSteps].quo << 1)
                                         : st_q[DivSteps].quo);

  `PTC_ASSERT(a_div_inv_zero, valid_o && invalid_o, quot_o == '0)
  `PTC_ASSERT_NEXT(a_div_hold, !en_i, $stable(valid_o))
  `PTC_ASSERT_NEXT(a_div_in, en_i && valid_i, vld_q[0])

endmodule

// ----- hw/rtl/ptc_back.sv -----
// Back stages: pressure correction terms and the final sum.
// Depends on ptc_pkg and the macro header.
`include "pressure_temp_compensation_core_macros.svh"
module ptc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  ptc_pkg::trim_t trim_i,
  input  ptc_pkg::word_t temp_i,
  input  ptc_pkg::word_t p_i,
  input  logic           invalid_i,
  output logic           valid_o,
  output ptc_pkg::word_t temp_o,
  output ptc_pkg::word_t press_o,
  output logic           invalid_o
);
  import ptc_pkg::*;

  logic  v1_q, v2_q, v3_q, inv1_q, inv2_q, inv3_q;
  word_t t1_q, t2_q, t3_q, p1_q, p2_q, p3_q;
  word_t sq_q, sq_d, b8_q, b8_d, a9_q, a9_d, fin_d, p_s;

  always_comb begin
    sq_d  = mul32(p_i >> 3, p_i >> 3) >> 13;
    b8_d  = asr(mul32(p1_q >> 2, sx16(trim_i.p8)), 13);
    a9_d  = asr(mul32(sx16(trim_i.p9), sq_q), 12);
    p_s   = a9_q + b8_q + sx16(trim_i.p7);
    fin_d = inv2_q ? '0 : (p2_q + asr(p_s, 4));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= temp_i; p1_q <= p_i; inv1_q <= invalid_i; sq_q <= sq_d;
      t2_q <= t1_q; p2_q <= p1_q; inv2_q <= inv1_q; a9_q <= a9_d;
      b8_q <= b8_d;
      t3_q <= t2_q; p3_q <= fin_d; inv3_q <= inv2_q;
    end
  end

  assign valid_o   = v3_q;
  assign temp_o    = t3_q;
  assign press_o   = p3_q;
  assign invalid_o = inv3_q;

  `PTC_ASSERT(a_back_inv, valid_o && invalid_o, press_o == '0)
  `PTC_ASSERT_NEXT(a_back_hold, !en_i, $stable(valid_o))

endmodule
